>>> rtl/skr_pkg.sv
// Shared types and codes for the key-removal stack.
// Beat structs for both channels, op and status codes, default depth.
// No dependencies.
`default_nettype none

package skr_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int KEY_W           = 32;
  localparam int DEPTH_W         = 7;

  // op codes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;  // no-op, answered with plain ok

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] popped_key;
    logic [DEPTH_W-1:0]      depth;
  } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/skr_store.sv
// Entry store: one write port, one read port with registered read data.
// Uses skr_pkg for the key width.
`default_nettype none

module skr_store #(
  parameter int DEPTH = skr_pkg::STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [AW-1:0]                   wr_addr,
  input  wire logic signed [skr_pkg::KEY_W-1:0] wr_data,
  input  wire logic                            rd_en,
  input  wire logic [AW-1:0]                   rd_addr,
  output logic signed [skr_pkg::KEY_W-1:0]     rd_data
);

  logic signed [skr_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/skr_ctrl.sv
// Sequencer for push, pop and the remove-by-key compaction walk.
// One key comparator is reused for every entry during a remove.
// Uses skr_pkg; drives the ports of skr_store.
`default_nettype none

module skr_ctrl #(
  parameter int DEPTH = skr_pkg::STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire skr_pkg::in_beat_t                in_beat,
  output logic                                  idle,
  output logic                                  res_valid,
  output skr_pkg::out_beat_t                    res,
  input  wire logic                             res_take,
  output logic                                  mem_we,
  output logic [AW-1:0]                         mem_waddr,
  output logic signed [skr_pkg::KEY_W-1:0]      mem_wdata,
  output logic                                  mem_re,
  output logic [AW-1:0]                         mem_raddr,
  input  wire logic signed [skr_pkg::KEY_W-1:0] mem_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_RM   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                       state;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    cnt_m1;
  logic [CW-1:0]                    rd;
  logic [CW-1:0]                    wr;
  logic                             pend;
  logic signed [skr_pkg::KEY_W-1:0] key;
  logic                             full;
  logic                             empty;
  logic                             keep;

  assign cnt_m1    = count - 1'b1;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign keep      = pend && (mem_rdata != key);
  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = in_beat.key;
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (state == S_IDLE && accept) begin
      if (in_beat.op == skr_pkg::OP_PUSH && !full) begin
        mem_we    = 1'b1;
        mem_waddr = count[AW-1:0];
      end
      if (in_beat.op == skr_pkg::OP_POP && !empty) begin
        mem_re    = 1'b1;
        mem_raddr = cnt_m1[AW-1:0];
      end
    end else if (state == S_RM) begin
      // compaction: surviving entry moves down to the write pointer
      if (keep) begin
        mem_we    = 1'b1;
        mem_waddr = wr[AW-1:0];
        mem_wdata = mem_rdata;
      end
      if (rd != count) begin
        mem_re    = 1'b1;
        mem_raddr = rd[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key            <= in_beat.key;
            res.popped_key <= '0;
            case (in_beat.op)
              skr_pkg::OP_PUSH: begin
                state <= S_DONE;
                if (full) begin
                  res.status <= skr_pkg::ST_FULL;
                  res.depth  <= skr_pkg::DEPTH_W'(count);
                end else begin
                  res.status <= skr_pkg::ST_OK;
                  res.depth  <= skr_pkg::DEPTH_W'(count + 1'b1);
                  count      <= count + 1'b1;
                end
              end
              skr_pkg::OP_POP: begin
                if (empty) begin
                  res.status <= skr_pkg::ST_EMPTY;
                  res.depth  <= skr_pkg::DEPTH_W'(count);
                  state      <= S_DONE;
                end else begin
                  res.status <= skr_pkg::ST_OK;
                  state      <= S_POP;
                end
              end
              skr_pkg::OP_REMOVE: begin
                rd    <= '0;
                wr    <= '0;
                pend  <= 1'b0;
                state <= S_RM;
              end
              default: begin
                res.status <= skr_pkg::ST_OK;
                res.depth  <= skr_pkg::DEPTH_W'(count);
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_POP: begin
          res.popped_key <= mem_rdata;
          res.depth      <= skr_pkg::DEPTH_W'(cnt_m1);
          count          <= cnt_m1;
          state          <= S_DONE;
        end
        S_RM: begin
          if (keep) begin
            wr <= wr + 1'b1;
          end
          if (rd != count) begin
            rd   <= rd + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (!pend && rd == count) begin
            count      <= wr;
            res.depth  <= skr_pkg::DEPTH_W'(wr);
            res.status <= (wr != count) ? skr_pkg::ST_OK : skr_pkg::ST_NOTFOUND;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/stack_with_key_removal.sv
// Top level of the bounded LIFO stack with delete-by-key.
// Depends on skr_pkg, skr_store and skr_ctrl.
//
// Bounded LIFO of signed 32-bit keys held in a single-port-write,
// single-port-read memory of STACK_DEPTH entries. Each input beat gives
// exactly one output beat carrying status, popped key and depth after the
// operation. Push, rejected pop and the unused op code set the result at
// the accept; a pop adds one memory read with registered data; a remove
// runs a walk that reads one entry per cycle through the memory read port
// and compares it against the key in one shared comparator, writing
// survivors back down in place. The block takes one beat at a time:
// in_stall is high from the accept until the result has moved into the
// output register, which then frees the input even while out_stall holds
// the result; the next beat can be taken in the following cycle.
// Push to a full stack and pop from an empty one leave the stack untouched.
// Depth is reported in 7 bits and wraps above 127.
// The memory has no reset and no clearing pass; only written entries are
// ever read.
`default_nettype none

module stack_with_key_removal #(
  parameter int STACK_DEPTH = skr_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire skr_pkg::in_beat_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output skr_pkg::out_beat_t       out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic                             idle;
  logic                             accept;
  logic                             res_valid;
  skr_pkg::out_beat_t               res;
  logic                             res_take;
  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic signed [skr_pkg::KEY_W-1:0] mem_wdata;
  logic                             mem_re;
  logic [AW-1:0]                    mem_raddr;
  logic signed [skr_pkg::KEY_W-1:0] mem_rdata;

  // input side: one beat in flight at a time
  assign in_stall = !idle;
  assign accept   = in_valid && idle;

  // result moves into the output register whenever it is empty or draining
  assign res_take = res_valid && (!out_valid || !out_stall);

  skr_ctrl #(
    .DEPTH(STACK_DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_beat  (in_data),
    .idle     (idle),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  skr_store #(
    .DEPTH(STACK_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  // output register: valid is control, beat payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/skr_checker.sv
// Port-level checks for stack_with_key_removal, bound to the top level.
// Uses skr_pkg status codes.
`default_nettype none

module skr_checker #(
  parameter int STACK_DEPTH = skr_pkg::STACK_DEPTH_DEF
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire skr_pkg::out_beat_t out_data
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while one is in work");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == skr_pkg::ST_EMPTY |->
      out_data.depth == '0 && out_data.popped_key == '0)
    else $error("empty status with nonzero depth or key");

  a_full_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == skr_pkg::ST_FULL |->
      out_data.depth == skr_pkg::DEPTH_W'(STACK_DEPTH) && out_data.popped_key == '0)
    else $error("full status with wrong depth or key");

endmodule

bind stack_with_key_removal skr_checker #(
  .STACK_DEPTH(STACK_DEPTH)
) u_skr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

>>> dv/tb_stack_with_key_removal.sv
// Self-checking testbench for stack_with_key_removal: push, pop and remove-by-key
// beats against a predictor of the bounded LIFO, with random idling on both channels.
// Depends on skr_pkg and the stack_with_key_removal RTL.
`timescale 1ns / 100ps

module tb_stack_with_key_removal;

  localparam int STACK_CAP      = skr_pkg::STACK_DEPTH_DEF;
  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int TOTAL_OPS      = 900;
  // Receiver hold-off long enough to back the stack up into its input.
  localparam int LONG_HOLD      = 300;
  localparam int LONG_HOLD_AT   = 200;
  // Worst correct quiet stretch: long hold-off plus a full-depth remove
  // walk plus the longest sender gap. Taken several times over.
  localparam int WATCHDOG_LIMIT = 5000;
  // Settle time is a multiple of the remove walk on a full stack.
  localparam int SETTLE_CYCLES  = 4 * (STACK_CAP + 3);
  localparam int MAX_REPORTS    = 200;

  typedef struct packed {
    logic              wait_idle;  // hold this beat until every result is back
    skr_pkg::in_beat_t beat;
  } queued_op_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  skr_pkg::in_beat_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  skr_pkg::out_beat_t out_data;

  stack_with_key_removal #(.STACK_DEPTH(STACK_CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow stack: entries below held_count only, index 0 is the bottom.
  // ---------------------------------------------------------------------
  logic signed [skr_pkg::KEY_W-1:0] held_keys [STACK_CAP];
  int                               held_count = 0;

  queued_op_t         queued_ops [$];
  skr_pkg::out_beat_t expected_results [$];

  // run statistics
  int n_push = 0, n_full = 0, n_pop = 0, n_empty = 0;
  int n_remove = 0, n_notfound = 0, n_removed_keys = 0, n_unused = 0;
  int peak_depth = 0;
  int results_seen = 0;
  int errors = 0;

  // Applies one op to the shadow stack and returns the result beat it owes.
  function automatic skr_pkg::out_beat_t apply_stack_op(skr_pkg::in_beat_t b);
    skr_pkg::out_beat_t r;
    int                 kept;
    int                 i;
    r.status     = skr_pkg::ST_OK;
    r.popped_key = '0;
    case (b.op)
      skr_pkg::OP_PUSH: begin
        n_push++;
        if (held_count >= STACK_CAP) begin
          r.status = skr_pkg::ST_FULL;
          n_full++;
        end else begin
          held_keys[held_count] = b.key;
          held_count++;
        end
      end
      skr_pkg::OP_POP: begin
        n_pop++;
        if (held_count == 0) begin
          r.status = skr_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          held_count--;
          r.popped_key = held_keys[held_count];
        end
      end
      skr_pkg::OP_REMOVE: begin
        // compact survivors downward, order kept
        n_remove++;
        kept = 0;
        for (i = 0; i < held_count; i++) begin
          if (held_keys[i] != b.key) begin
            held_keys[kept] = held_keys[i];
            kept++;
          end
        end
        if (kept == held_count) begin
          r.status = skr_pkg::ST_NOTFOUND;
          n_notfound++;
        end
        n_removed_keys += held_count - kept;
        held_count = kept;
      end
      default: n_unused++;  // unused op code: no change, plain ok
    endcase
    r.depth = skr_pkg::DEPTH_W'(held_count);
    if (held_count > peak_depth) peak_depth = held_count;
    return r;
  endfunction

  // Gap / stall length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Keys come mostly from a small pool so removes actually hit.
  logic [skr_pkg::KEY_W-1:0] key_pool [8];

  function automatic logic [skr_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 6) return key_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic add_op(logic [1:0] op, logic [skr_pkg::KEY_W-1:0] key, logic wait_idle);
    queued_op_t q;
    q.wait_idle = wait_idle;
    q.beat.op   = op;
    q.beat.key  = key;
    queued_ops.push_back(q);
  endtask

  // ---------------------------------------------------------------------
  // Driver: input side, changes on the falling edge.
  // in_taken records whether the beat on the bus went in at the last edge.
  // ---------------------------------------------------------------------
  logic in_taken = 1'b0;
  int   send_gap = 0, send_quiet = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled: hold the beat as is
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (queued_ops.size() != 0 &&
                 !(queued_ops[0].wait_idle && expected_results.size() != 0)) begin
      in_valid <= 1'b1;
      in_data  <= queued_ops[0].beat;
      void'(queued_ops.pop_front());
      if (send_quiet > 0) begin
        send_quiet <= send_quiet - 1;
        send_gap   <= 0;
      end else if ($urandom_range(0, 29) == 0) begin
        send_quiet <= $urandom_range(20, 60);
        send_gap   <= 0;
      end else begin
        send_gap <= pick_gap();
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: out_stall pattern, plus one long hold-off once enough
  // results have come so the block backs up and stalls its input.
  // ---------------------------------------------------------------------
  int   recv_hold = 0, recv_quiet = 0, stall_len;
  logic long_hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      recv_hold      <= LONG_HOLD - 1;
      out_stall      <= 1'b1;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_stall <= 1'b1;
    end else if (recv_quiet > 0) begin
      recv_quiet <= recv_quiet - 1;
      out_stall  <= 1'b0;
    end else if ($urandom_range(0, 29) == 0) begin
      recv_quiet <= $urandom_range(20, 60);
      out_stall  <= 1'b0;
    end else begin
      stall_len = pick_gap();
      if (stall_len == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        recv_hold <= stall_len - 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and predictor on the rising edge. The output beat is checked
  // before a new expectation is queued, so a beat taken in this same cycle
  // can never be matched to its own input.
  // ---------------------------------------------------------------------
  skr_pkg::out_beat_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result beat: status=%0d popped_key=%0d depth=%0d",
                     $time, out_data.status, out_data.popped_key, out_data.depth);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status ||
              out_data.popped_key !== want.popped_key ||
              out_data.depth !== want.depth) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $write("%0t: result mismatch: expected status=%0d popped_key=%0d depth=%0d",
                     $time, want.status, want.popped_key, want.depth);
              $display(", got status=%0d popped_key=%0d depth=%0d",
                       out_data.status, out_data.popped_key, out_data.depth);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_stack_op(in_data));
    end
    in_taken <= !rst && in_valid && !in_stall;
  end

  // Watchdog: cycles with no beat on either channel.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, expected_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  int   phase, len, j, r;
  logic hold_first;

  initial begin
    key_pool[0] = 32'h7FFF_FFFF;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (j = 4; j < 8; j++) key_pool[j] = $urandom();

    // Directed: empty-stack corners, key extremes, multi-match removes.
    add_op(skr_pkg::OP_POP,    32'h0000_0000, 1'b0);   // pop on empty
    add_op(skr_pkg::OP_REMOVE, 32'h0000_0000, 1'b0);   // remove on empty
    add_op(skr_pkg::OP_UNUSED, 32'h5555_5555, 1'b0);   // unused op code
    add_op(skr_pkg::OP_PUSH,   32'h7FFF_FFFF, 1'b0);
    add_op(skr_pkg::OP_PUSH,   32'h8000_0000, 1'b0);
    add_op(skr_pkg::OP_PUSH,   32'h0000_0000, 1'b0);
    add_op(skr_pkg::OP_PUSH,   32'hFFFF_FFFF, 1'b0);
    add_op(skr_pkg::OP_PUSH,   32'h7FFF_FFFF, 1'b0);
    add_op(skr_pkg::OP_PUSH,   32'h0000_0000, 1'b0);
    add_op(skr_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b0);   // two hits, bottom and middle
    add_op(skr_pkg::OP_REMOVE, 32'h0000_0001, 1'b0);   // no match on non-empty stack
    add_op(skr_pkg::OP_UNUSED, 32'hAAAA_AAAA, 1'b0);
    add_op(skr_pkg::OP_REMOVE, 32'h0000_0000, 1'b0);   // hits including top
    add_op(skr_pkg::OP_POP,    32'hAAAA_AAAA, 1'b0);
    add_op(skr_pkg::OP_POP,    32'h5555_5555, 1'b0);
    add_op(skr_pkg::OP_POP,    32'hFFFF_FFFF, 1'b0);   // empty again
    add_op(skr_pkg::OP_PUSH,   32'd5, 1'b0);
    add_op(skr_pkg::OP_PUSH,   32'd9, 1'b0);
    add_op(skr_pkg::OP_PUSH,   32'd5, 1'b0);
    add_op(skr_pkg::OP_PUSH,   32'd5, 1'b0);
    add_op(skr_pkg::OP_REMOVE, 32'd5, 1'b0);           // leaves one survivor
    add_op(skr_pkg::OP_REMOVE, 32'd9, 1'b0);           // removes the last entry
    add_op(skr_pkg::OP_POP,    32'd0, 1'b0);

    // Random phases: fill runs (reach full and push past it), drain runs,
    // mixed traffic on a small key pool, and raw noise.
    hold_first = 1'b1;
    while (queued_ops.size() < TOTAL_OPS) begin
      phase = $urandom_range(0, 99);
      if (phase < 20) begin
        len = $urandom_range(10, 70);
        for (j = 0; j < len; j++)
          add_op(skr_pkg::OP_PUSH, pick_key(), j == 0 && hold_first);
      end else if (phase < 33) begin
        len = $urandom_range(5, 70);
        for (j = 0; j < len; j++)
          add_op(skr_pkg::OP_POP, $urandom(), j == 0 && hold_first);
      end else if (phase < 93) begin
        len = $urandom_range(20, 40);
        for (j = 0; j < len; j++) begin
          r = $urandom_range(0, 99);
          if (r < 45)      add_op(skr_pkg::OP_PUSH,   pick_key(), j == 0 && hold_first);
          else if (r < 70) add_op(skr_pkg::OP_POP,    $urandom(), j == 0 && hold_first);
          else if (r < 97) add_op(skr_pkg::OP_REMOVE, pick_key(), j == 0 && hold_first);
          else             add_op(skr_pkg::OP_UNUSED, $urandom(), j == 0 && hold_first);
        end
      end else begin
        len = $urandom_range(5, 15);
        for (j = 0; j < len; j++)
          add_op(2'($urandom_range(0, 3)), $urandom(), j == 0 && hold_first);
      end
      // sender waits for a fully drained block now and then
      hold_first = ($urandom_range(0, 9) == 0);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (queued_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end

    $display("Coverage: %0d pushes (%0d refused as full), %0d pops (%0d on empty), %0d unused",
             n_push, n_full, n_pop, n_empty, n_unused);
    $display("Coverage: %0d removes (%0d missed, %0d keys deleted), peak depth %0d, %0d results",
             n_remove, n_notfound, n_removed_keys, peak_depth, results_seen);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
